### design/bmsi_pkg.sv
`default_nettype none

package bmsi_pkg;

	// work ram geometry
	localparam int unsigned WORK_RAM_BYTES = 1024;
	localparam int unsigned RAM_AW = $clog2(WORK_RAM_BYTES);

	// a12 filter length in ppu cycles
	localparam logic [3:0] A12_FILTER_CYCLES = 4'd8;

	// fixed prg banks
	localparam logic [5:0] PRG_FIXED_LO = 6'h3E;
	localparam logic [5:0] PRG_FIXED_HI = 6'h3F;

	// ram enable reset values per variant
	localparam logic [3:0] RAM_EN_BASE = 4'h8;
	localparam logic [3:0] RAM_EN_VARIANT = 4'h0;

	// configuration register indexes
	localparam logic [1:0] CFG_CHIP_VARIANT = 2'd0;
	localparam logic [1:0] CFG_FOUR_SCREEN = 2'd1;
	localparam logic [1:0] CFG_CHR_IS_RAM = 2'd2;

	// mirroring codes
	localparam logic [1:0] MIRROR_FOUR_SCREEN = 2'd2;

	typedef enum logic [1:0] {
		OP_CPU_WRITE = 2'd0,
		OP_CPU_READ  = 2'd1,
		OP_PPU_CYCLE = 2'd2,
		OP_IDLE      = 2'd3
	} op_t;

	// register select: cpu_addr bits 14:13 and 0
	typedef enum logic [2:0] {
		SEL_BANK_CMD   = 3'b000,
		SEL_BANK_DATA  = 3'b001,
		SEL_MIRROR     = 3'b010,
		SEL_RAM_PROT   = 3'b011,
		SEL_IRQ_LATCH  = 3'b100,
		SEL_IRQ_RELOAD = 3'b101,
		SEL_IRQ_OFF    = 3'b110,
		SEL_IRQ_ON     = 3'b111
	} reg_sel_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] cpu_addr;
		logic [7:0]  write_data;
		logic [13:0] ppu_addr;
	} evt_t;

	typedef struct packed {
		logic        irq_line;
		logic [7:0]  read_data;
		logic [5:0]  prg_bank;
		logic [7:0]  chr_bank;
		logic [1:0]  mirror_mode;
	} res_t;

	// mapper outputs without the ram read byte
	typedef struct packed {
		logic        irq_line;
		logic [5:0]  prg_bank;
		logic [7:0]  chr_bank;
		logic [1:0]  mirror_mode;
	} map_t;

	// work ram access request from the core
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        wdata;
	} ram_req_t;

endpackage

`default_nettype wire

### design/bmsi_ifs.sv
`default_nettype none

// bus event channel
interface bmsi_evt_if;
	logic             valid;
	logic             ready;
	bmsi_pkg::evt_t   item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// result channel
interface bmsi_res_if;
	logic             valid;
	logic             ready;
	bmsi_pkg::res_t   item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### design/bmsi_ram.sv
`default_nettype none

module bmsi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### design/bmsi_core.sv
`default_nettype none

module bmsi_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire bmsi_pkg::evt_t      evt,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic                cfg_data,
	output bmsi_pkg::map_t           map,
	output bmsi_pkg::ram_req_t       ram_req
);

	// configuration
	logic chip_variant_q, four_screen_q, chr_is_ram_q;

	// mapper state
	logic [7:0] cmd_q, cmd_n;
	logic [7:0] chr_q [8];
	logic [7:0] chr_n [8];
	logic [5:0] prg0_q, prg0_n, prg1_q, prg1_n;
	logic       mirror_q, mirror_n;
	logic [3:0] ram_en_q, ram_en_n;
	logic [7:0] latch_q, latch_n, count_q, count_n;
	logic       irq_on_q, irq_on_n, reload_q, reload_n;
	logic [3:0] wait_q, wait_n;
	logic       irq_q, irq_n;

	// next state for one event
	always_comb begin
		logic [3:0]          wait_dec;
		logic                a12;
		logic                in_lo, in_hi;
		bmsi_pkg::reg_sel_t  sel;

		cmd_n    = cmd_q;
		chr_n    = chr_q;
		prg0_n   = prg0_q;
		prg1_n   = prg1_q;
		mirror_n = mirror_q;
		ram_en_n = ram_en_q;
		latch_n  = latch_q;
		count_n  = count_q;
		irq_on_n = irq_on_q;
		reload_n = reload_q;
		wait_n   = wait_q;
		irq_n    = irq_q;

		ram_req.wr    = 1'b0;
		ram_req.rd    = 1'b0;
		ram_req.addr  = evt.cpu_addr[bmsi_pkg::RAM_AW-1:0];
		ram_req.wdata = evt.write_data;

		a12      = evt.ppu_addr[12];
		wait_dec = (wait_q != 4'd0) ? wait_q - 4'd1 : 4'd0;
		in_lo    = (evt.cpu_addr[15:9] == 7'b0111000);
		in_hi    = (evt.cpu_addr[15:9] == 7'b0111001);
		sel      = bmsi_pkg::reg_sel_t'({evt.cpu_addr[14:13], evt.cpu_addr[0]});

		if (step) begin
			case (evt.op)
				bmsi_pkg::OP_CPU_WRITE: begin
					if (evt.cpu_addr[15]) begin
						case (sel)
							bmsi_pkg::SEL_BANK_CMD: begin
								cmd_n = evt.write_data;
								if (!evt.write_data[5]) begin
									ram_en_n = 4'h0;
								end
							end
							bmsi_pkg::SEL_BANK_DATA: begin
								case (cmd_q[2:0])
									3'd0: begin
										chr_n[0] = {evt.write_data[7:1], 1'b0};
										chr_n[1] = {evt.write_data[7:1], 1'b1};
									end
									3'd1: begin
										chr_n[2] = {evt.write_data[7:1], 1'b0};
										chr_n[3] = {evt.write_data[7:1], 1'b1};
									end
									3'd2: chr_n[4] = evt.write_data;
									3'd3: chr_n[5] = evt.write_data;
									3'd4: chr_n[6] = evt.write_data;
									3'd5: chr_n[7] = evt.write_data;
									3'd6: prg0_n = evt.write_data[5:0];
									default: prg1_n = evt.write_data[5:0];
								endcase
							end
							bmsi_pkg::SEL_MIRROR: mirror_n = ~evt.write_data[0];
							bmsi_pkg::SEL_RAM_PROT: begin
								if (chip_variant_q) begin
									if (cmd_q[5]) begin
										ram_en_n = evt.write_data[7:4];
									end
								end else begin
									ram_en_n = {evt.write_data[7:6], 2'b00};
								end
							end
							bmsi_pkg::SEL_IRQ_LATCH: latch_n = evt.write_data;
							bmsi_pkg::SEL_IRQ_RELOAD: begin
								count_n  = 8'd0;
								reload_n = 1'b1;
							end
							bmsi_pkg::SEL_IRQ_OFF: begin
								irq_on_n = 1'b0;
								irq_n    = 1'b0;
							end
							default: irq_on_n = 1'b1;
						endcase
					end else if (chip_variant_q && cmd_q[5]) begin
						ram_req.wr = (in_lo && ram_en_q[0]) || (in_hi && ram_en_q[2]);
					end
				end
				bmsi_pkg::OP_CPU_READ: begin
					ram_req.rd = chip_variant_q && cmd_q[5] &&
						((in_lo && ram_en_q[1]) || (in_hi && ram_en_q[3]));
				end
				bmsi_pkg::OP_PPU_CYCLE: begin
					// filtered a12 rise clocks the scanline counter
					if (wait_dec == 4'd0 && a12) begin
						if (count_q == 8'd0 || reload_q) begin
							count_n = latch_q;
						end else begin
							count_n = count_q - 8'd1;
						end
						if ((count_q != 8'd0 || reload_q) && count_n == 8'd0 && irq_on_q) begin
							irq_n = 1'b1;
						end
						reload_n = 1'b0;
					end
					wait_n = a12 ? bmsi_pkg::A12_FILTER_CYCLES : wait_dec;
				end
				default: begin
				end
			endcase
		end

		// variant select reloads the ram enables
		if (cfg_we && cfg_index == bmsi_pkg::CFG_CHIP_VARIANT) begin
			ram_en_n = cfg_data ? bmsi_pkg::RAM_EN_VARIANT : bmsi_pkg::RAM_EN_BASE;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_variant_q <= 1'b0;
			four_screen_q  <= 1'b0;
			chr_is_ram_q   <= 1'b0;
			cmd_q          <= 8'd0;
			for (int i = 0; i < 8; i++) begin
				chr_q[i] <= 8'(i);
			end
			prg0_q   <= 6'h3C;
			prg1_q   <= 6'h3D;
			mirror_q <= 1'b0;
			ram_en_q <= bmsi_pkg::RAM_EN_BASE;
			latch_q  <= 8'd0;
			count_q  <= 8'd0;
			irq_on_q <= 1'b0;
			reload_q <= 1'b0;
			wait_q   <= 4'd0;
			irq_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bmsi_pkg::CFG_CHIP_VARIANT: chip_variant_q <= cfg_data;
					bmsi_pkg::CFG_FOUR_SCREEN: four_screen_q <= cfg_data;
					bmsi_pkg::CFG_CHR_IS_RAM: chr_is_ram_q <= cfg_data;
					default: begin
					end
				endcase
			end
			cmd_q    <= cmd_n;
			chr_q    <= chr_n;
			prg0_q   <= prg0_n;
			prg1_q   <= prg1_n;
			mirror_q <= mirror_n;
			ram_en_q <= ram_en_n;
			latch_q  <= latch_n;
			count_q  <= count_n;
			irq_on_q <= irq_on_n;
			reload_q <= reload_n;
			wait_q   <= wait_n;
			irq_q    <= irq_n;
		end
	end

	// bank lookup on the updated state
	always_comb begin
		logic [1:0] pslot;
		logic [2:0] cslot;
		logic [7:0] cbank;

		pslot = evt.cpu_addr[14:13];
		if (!pslot[0]) begin
			pslot[1] = pslot[1] ^ cmd_n[6];
		end
		case (pslot)
			2'd0: map.prg_bank = prg0_n;
			2'd1: map.prg_bank = prg1_n;
			2'd2: map.prg_bank = bmsi_pkg::PRG_FIXED_LO;
			default: map.prg_bank = bmsi_pkg::PRG_FIXED_HI;
		endcase

		cslot = evt.ppu_addr[12:10] ^ {cmd_n[7], 2'b00};
		cbank = chr_n[cslot];
		map.chr_bank = chr_is_ram_q ? {5'd0, cbank[2:0]} : cbank;

		map.mirror_mode = four_screen_q ? bmsi_pkg::MIRROR_FOUR_SCREEN : {1'b0, ~mirror_n};
		map.irq_line    = irq_n;
	end

endmodule

`default_nettype wire

### design/bank_mapper_scanline_irq_unit.sv
// Bank mapper with scanline IRQ counter.
// evt channel: one bus event per transaction (cpu write, cpu read, ppu bus
// cycle, idle). res channel: one result transaction per event, giving the
// irq level, work ram read byte, prg and chr bank and mirroring as they
// stand after the event.
// Configuration: cfg_we/cfg_index/cfg_data write chip variant, four-screen
// and chr-ram flags; the user must write them only while no event is in
// flight, and the block itself does not enforce this. An accepted event
// is held in the event register, and its result in the result register.
// Throughput: one event per cycle while res.ready is high and the ram
// clear has ended; a new event is taken while the last result is held.
// Reset: all mapper state goes to its power-up value, then the 1 KB work
// ram is cleared one byte per cycle; evt.ready stays low until the clear
// ends. Configuration writes are taken during the clear.
// Receiver stall: while res.valid is high and res.ready low, the pipeline
// holds and evt.ready drops in the same cycle, so nothing is lost.
`default_nettype none

module bank_mapper_scanline_irq_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bmsi_evt_if.sink         evt,
	bmsi_res_if.source       res,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic        cfg_data
);

	logic                       adv;
	logic                       step;
	logic                       valid_s1;
	bmsi_pkg::evt_t             evt_s1;
	logic                       valid_s2;
	bmsi_pkg::map_t             map_s2;
	logic                       rd_hit_s2;
	bmsi_pkg::map_t             map;
	bmsi_pkg::ram_req_t         ram_req;
	logic                       clr_busy_q;
	logic [bmsi_pkg::RAM_AW-1:0] clr_addr_q;
	logic                       ram_en;
	logic                       ram_we;
	logic [bmsi_pkg::RAM_AW-1:0] ram_addr;
	logic [7:0]                 ram_wdata;
	logic [7:0]                 ram_rdata;

	// pipeline advance when the result register is free or drains
	assign adv       = !valid_s2 || res.ready;
	assign step      = valid_s1 && adv;
	assign evt.ready = adv && !clr_busy_q;

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= evt.valid && evt.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1 <= evt.item;
		end
	end

	bmsi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.evt       (evt_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.map       (map),
		.ram_req   (ram_req)
	);

	// work ram clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {bmsi_pkg::RAM_AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ram port mux between clear sweep and event access
	assign ram_we    = clr_busy_q || (step && ram_req.wr);
	assign ram_en    = clr_busy_q || (step && (ram_req.wr || ram_req.rd));
	assign ram_addr  = clr_busy_q ? clr_addr_q : ram_req.addr;
	assign ram_wdata = clr_busy_q ? 8'd0 : ram_req.wdata;

	bmsi_ram #(
		.WIDTH (8),
		.DEPTH (bmsi_pkg::WORK_RAM_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			map_s2    <= map;
			rd_hit_s2 <= ram_req.rd;
		end
	end

	assign res.valid            = valid_s2;
	assign res.item.irq_line    = map_s2.irq_line;
	assign res.item.read_data   = rd_hit_s2 ? ram_rdata : 8'd0;
	assign res.item.prg_bank    = map_s2.prg_bank;
	assign res.item.chr_bank    = map_s2.chr_bank;
	assign res.item.mirror_mode = map_s2.mirror_mode;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;
	import bmsi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_EVENTS = 85;
	localparam int PRESSURE_EVENTS = 40;

	// spare configuration index, the block ignores it
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam logic [1:0] MIRROR_VERTICAL = 2'd0;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;

	// bank command bits
	localparam int CMD_BIT_RAM = 5;
	localparam int CMD_BIT_PRG_SWAP = 6;
	localparam int CMD_BIT_CHR_SWAP = 7;

	// work ram protect bits
	localparam int PROT_WR_LO = 0;
	localparam int PROT_RD_LO = 1;
	localparam int PROT_WR_HI = 2;
	localparam int PROT_RD_HI = 3;

	localparam logic [15:0] WRAM_LO = 16'h7000;
	localparam logic [15:0] WRAM_HI = 16'h7200;
	localparam logic [15:0] WRAM_END = 16'h7400;

	// bank data target, low three bits of the bank command
	typedef enum logic [2:0] {
		BANK_CHR_0_1 = 3'd0,
		BANK_CHR_2_3 = 3'd1,
		BANK_CHR_4   = 3'd2,
		BANK_CHR_5   = 3'd3,
		BANK_CHR_6   = 3'd4,
		BANK_CHR_7   = 3'd5,
		BANK_PRG_0   = 3'd6,
		BANK_PRG_1   = 3'd7
	} bank_sel_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic       cfg_data;

	bmsi_evt_if evt_ch();
	bmsi_res_if res_ch();

	bank_mapper_scanline_irq_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mapper state as predicted
	logic       variant_sel;
	logic       four_screen_sel;
	logic       chr_ram_sel;
	logic [7:0] cmd_reg;
	logic [7:0] chr_bank_reg [8];
	logic [5:0] prg_bank_reg [2];
	logic       mirror_vert;
	logic [3:0] ram_prot;
	logic [7:0] irq_reload_val;
	logic [7:0] scan_count;
	logic       irq_enabled;
	logic       reload_req;
	logic       irq_level;
	logic [3:0] a12_holdoff;
	logic [7:0] wram [WORK_RAM_BYTES];

	res_t pending_results [$];
	int   fail_count = 0;
	int   events_accepted = 0;
	int   idle_cycles = 0;
	bit   no_gaps = 1'b0;
	bit   hold_req = 1'b0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// power-up state of the mapper
	function automatic void reset_mapper_state();
		variant_sel = 1'b0;
		four_screen_sel = 1'b0;
		chr_ram_sel = 1'b0;
		cmd_reg = '0;
		for (int i = 0; i < 8; i++)
			chr_bank_reg[i] = 8'(i);
		prg_bank_reg[0] = 6'h3C;
		prg_bank_reg[1] = 6'h3D;
		mirror_vert = 1'b0;
		ram_prot = RAM_EN_BASE;
		irq_reload_val = '0;
		scan_count = '0;
		irq_enabled = 1'b0;
		reload_req = 1'b0;
		irq_level = 1'b0;
		a12_holdoff = '0;
		for (int i = 0; i < WORK_RAM_BYTES; i++)
			wram[i] = '0;
	endfunction

	// work ram window and its enables
	function automatic bit ram_allowed(logic [15:0] addr, bit wr);
		if (!cmd_reg[CMD_BIT_RAM])
			return 1'b0;
		if (addr >= WRAM_LO && addr < WRAM_HI)
			return wr ? ram_prot[PROT_WR_LO] : ram_prot[PROT_RD_LO];
		if (addr >= WRAM_HI && addr < WRAM_END)
			return wr ? ram_prot[PROT_WR_HI] : ram_prot[PROT_RD_HI];
		return 1'b0;
	endfunction

	// register file write, decoded on address bits 14:13 and 0
	function automatic void write_register(logic [15:0] addr, logic [7:0] d);
		reg_sel_t sel;
		sel = reg_sel_t'({addr[14:13], addr[0]});
		case (sel)
			SEL_BANK_CMD: begin
				cmd_reg = d;
				if (!d[CMD_BIT_RAM])
					ram_prot = '0;
			end
			SEL_BANK_DATA: begin
				case (bank_sel_t'(cmd_reg[2:0]))
					BANK_CHR_0_1: begin
						chr_bank_reg[0] = {d[7:1], 1'b0};
						chr_bank_reg[1] = {d[7:1], 1'b1};
					end
					BANK_CHR_2_3: begin
						chr_bank_reg[2] = {d[7:1], 1'b0};
						chr_bank_reg[3] = {d[7:1], 1'b1};
					end
					BANK_CHR_4: chr_bank_reg[4] = d;
					BANK_CHR_5: chr_bank_reg[5] = d;
					BANK_CHR_6: chr_bank_reg[6] = d;
					BANK_CHR_7: chr_bank_reg[7] = d;
					BANK_PRG_0: prg_bank_reg[0] = d[5:0];
					default: prg_bank_reg[1] = d[5:0];
				endcase
			end
			SEL_MIRROR: mirror_vert = ~d[0];
			SEL_RAM_PROT: begin
				if (variant_sel) begin
					if (cmd_reg[CMD_BIT_RAM])
						ram_prot = d[7:4];
				end else begin
					ram_prot = {d[7:6], 2'b00};
				end
			end
			SEL_IRQ_LATCH: irq_reload_val = d;
			SEL_IRQ_RELOAD: begin
				scan_count = '0;
				reload_req = 1'b1;
			end
			SEL_IRQ_OFF: begin
				irq_enabled = 1'b0;
				irq_level = 1'b0;
			end
			default: irq_enabled = 1'b1;
		endcase
	endfunction

	// scanline counter, clocked by a12 once the filter has run out
	function automatic void ppu_clock(logic a12);
		logic [7:0] prev;
		if (a12_holdoff != 0)
			a12_holdoff--;
		if (a12_holdoff == 0 && a12) begin
			prev = scan_count;
			if (scan_count == 0 || reload_req)
				scan_count = irq_reload_val;
			else
				scan_count--;
			if ((prev != 0 || reload_req) && scan_count == 0 && irq_enabled)
				irq_level = 1'b1;
			reload_req = 1'b0;
		end
		if (a12)
			a12_holdoff = A12_FILTER_CYCLES;
	endfunction

	// apply one bus event and report the mapper outputs after it
	function automatic res_t apply_event(evt_t e);
		res_t       r;
		logic [1:0] pslot;
		logic [2:0] cslot;
		logic [7:0] cbank;
		r = '0;
		case (e.op)
			OP_CPU_WRITE: begin
				if (e.cpu_addr[15])
					write_register(e.cpu_addr, e.write_data);
				else if (variant_sel && ram_allowed(e.cpu_addr, 1'b1))
					wram[e.cpu_addr[RAM_AW-1:0]] = e.write_data;
			end
			OP_CPU_READ: begin
				if (variant_sel && ram_allowed(e.cpu_addr, 1'b0))
					r.read_data = wram[e.cpu_addr[RAM_AW-1:0]];
			end
			OP_PPU_CYCLE: ppu_clock(e.ppu_addr[12]);
			default: ;
		endcase
		r.irq_line = irq_level;
		pslot = e.cpu_addr[14:13];
		if (!pslot[0] && cmd_reg[CMD_BIT_PRG_SWAP])
			pslot[1] = ~pslot[1];
		if (pslot[1])
			r.prg_bank = pslot[0] ? PRG_FIXED_HI : PRG_FIXED_LO;
		else
			r.prg_bank = prg_bank_reg[pslot[0]];
		cslot = e.ppu_addr[12:10] ^ {cmd_reg[CMD_BIT_CHR_SWAP], 2'b00};
		cbank = chr_bank_reg[cslot];
		r.chr_bank = chr_ram_sel ? {5'd0, cbank[2:0]} : cbank;
		if (four_screen_sel)
			r.mirror_mode = MIRROR_FOUR_SCREEN;
		else
			r.mirror_mode = mirror_vert ? MIRROR_VERTICAL : MIRROR_HORIZONTAL;
		return r;
	endfunction

	// offer one event, predict its result once the transaction completes
	task automatic send_event(evt_t e);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		@(negedge clk);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.item <= e;
		evt_ch.valid <= 1'b1;
		do @(posedge clk); while (!evt_ch.ready);
		pending_results.push_back(apply_event(e));
		events_accepted++;
	endtask

	task automatic cpu_write(logic [15:0] addr, logic [7:0] data);
		send_event('{OP_CPU_WRITE, addr, data, 14'($urandom)});
	endtask

	task automatic cpu_read(logic [15:0] addr);
		send_event('{OP_CPU_READ, addr, 8'($urandom), 14'($urandom)});
	endtask

	task automatic ppu_cycle(logic a12);
		logic [13:0] paddr;
		paddr = 14'($urandom);
		paddr[12] = a12;
		send_event('{OP_PPU_CYCLE, 16'($urandom), 8'($urandom), paddr});
	endtask

	// register address with random don't-care bits
	function automatic logic [15:0] reg_addr(reg_sel_t sel);
		return {1'b1, sel[2:1], 12'($urandom), sel[0]};
	endfunction

	function automatic logic [15:0] wram_addr();
		return WRAM_LO + 16'($urandom_range(0, WORK_RAM_BYTES - 1));
	endfunction

	// stop offering and wait for every result to come back
	task automatic wait_until_drained();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [1:0] index, logic value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_CHIP_VARIANT: begin
				variant_sel = value;
				ram_prot = value ? RAM_EN_VARIANT : RAM_EN_BASE;
			end
			CFG_FOUR_SCREEN: four_screen_sel = value;
			CFG_CHR_IS_RAM: chr_ram_sel = value;
			default: ;
		endcase
	endtask

	task automatic set_config(logic variant, logic four, logic chr_ram);
		wait_until_drained();
		write_config(CFG_CHIP_VARIANT, variant);
		write_config(CFG_FOUR_SCREEN, four);
		write_config(CFG_CHR_IS_RAM, chr_ram);
	endtask

	// compare one result transaction against the oldest prediction
	task automatic check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result transaction %p", got);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.irq_line !== want.irq_line) begin
			$error("irq_line expected %0h actual %0h", want.irq_line, got.irq_line);
			fail_count++;
		end
		if (got.read_data !== want.read_data) begin
			$error("read_data expected %0h actual %0h", want.read_data, got.read_data);
			fail_count++;
		end
		if (got.prg_bank !== want.prg_bank) begin
			$error("prg_bank expected %0h actual %0h", want.prg_bank, got.prg_bank);
			fail_count++;
		end
		if (got.chr_bank !== want.chr_bank) begin
			$error("chr_bank expected %0h actual %0h", want.chr_bank, got.chr_bank);
			fail_count++;
		end
		if (got.mirror_mode !== want.mirror_mode) begin
			$error("mirror_mode expected %0h actual %0h", want.mirror_mode, got.mirror_mode);
			fail_count++;
		end
	endtask

	// result receiver with random stalls and an occasional long hold
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			stall = no_gaps ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			check_result(res_ch.item);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// power-up values, idle op and field extremes
	task automatic test_reset_values();
		set_config(1'b0, 1'b0, 1'b0);
		send_event('{OP_IDLE, 16'hFFFF, 8'hFF, 14'h3FFF});
		send_event('{OP_CPU_READ, 16'h0000, 8'h00, 14'h0000});
		cpu_read(WRAM_LO);
	endtask

	// bank command, bank data and the prg/chr swap bits
	task automatic test_bank_switching();
		cpu_write(reg_addr(SEL_BANK_CMD), {2'b11, 3'b000, BANK_PRG_1});
		cpu_write(reg_addr(SEL_BANK_DATA), 8'hFF);
		cpu_read(16'hC000);
		cpu_write(reg_addr(SEL_BANK_CMD), {5'b00000, BANK_CHR_0_1});
		cpu_write(reg_addr(SEL_BANK_DATA), 8'hFF);
		cpu_write(reg_addr(SEL_MIRROR), 8'h01);
		cpu_write(reg_addr(SEL_RAM_PROT), 8'hF0);
	endtask

	// zero latch after reload raises irq on the first a12 rise
	task automatic test_scanline_irq();
		cpu_write(reg_addr(SEL_IRQ_LATCH), 8'h00);
		cpu_write(reg_addr(SEL_IRQ_RELOAD), 8'h00);
		cpu_write(reg_addr(SEL_IRQ_ON), 8'h00);
		ppu_cycle(1'b1);
		cpu_write(reg_addr(SEL_IRQ_OFF), 8'h00);
	endtask

	// variant work ram: both halves, the window edges and the gates
	task automatic test_work_ram();
		set_config(1'b1, 1'b1, 1'b1);
		write_config(CFG_SPARE, 1'b1);
		cpu_write(reg_addr(SEL_BANK_CMD), 8'h20);
		cpu_write(reg_addr(SEL_RAM_PROT), 8'hF0);
		cpu_write(WRAM_LO, 8'hFF);
		cpu_write(WRAM_END - 16'd1, 8'hA5);
		cpu_read(WRAM_LO);
		cpu_read(WRAM_END - 16'd1);
		cpu_read(WRAM_END);
		cpu_write(WRAM_LO - 16'd1, 8'h55);
		cpu_write(reg_addr(SEL_RAM_PROT), 8'h00);
		cpu_read(WRAM_LO);
	endtask

	// scanlines: runs of a12 low followed by a short a12 high burst
	task automatic scanline_burst();
		int lines;
		int low_run;
		int high_run;
		lines = $urandom_range(1, 4);
		repeat (lines) begin
			low_run = $urandom_range(0, 10);
			high_run = $urandom_range(1, 3);
			repeat (low_run) ppu_cycle(1'b0);
			repeat (high_run) ppu_cycle(1'b1);
		end
	endtask

	task automatic irq_setup_burst();
		logic [7:0] latch;
		latch = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		cpu_write(reg_addr(SEL_IRQ_LATCH), latch);
		if ($urandom_range(0, 1))
			cpu_write(reg_addr(SEL_IRQ_RELOAD), 8'($urandom));
		if ($urandom_range(0, 3) != 0)
			cpu_write(reg_addr(SEL_IRQ_ON), 8'($urandom));
		else
			cpu_write(reg_addr(SEL_IRQ_OFF), 8'($urandom));
	endtask

	task automatic bank_burst();
		cpu_write(reg_addr(SEL_BANK_CMD), 8'($urandom));
		cpu_write(reg_addr(SEL_BANK_DATA), 8'($urandom));
		if ($urandom_range(0, 2) == 0)
			cpu_write(reg_addr(SEL_MIRROR), 8'($urandom));
		cpu_read(16'($urandom));
	endtask

	task automatic wram_burst();
		logic [7:0] cmd;
		int         n;
		cmd = 8'($urandom);
		cmd[CMD_BIT_RAM] = 1'b1;
		cpu_write(reg_addr(SEL_BANK_CMD), cmd);
		cpu_write(reg_addr(SEL_RAM_PROT), 8'($urandom));
		n = $urandom_range(4, 8);
		repeat (n) begin
			if ($urandom_range(0, 1))
				cpu_write(wram_addr(), 8'($urandom));
			else
				cpu_read(wram_addr());
		end
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 4))
			send_event('{op_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
				14'($urandom)});
	endtask

	task automatic run_traffic(int count);
		int start;
		int pick;
		start = events_accepted;
		while (events_accepted - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				scanline_burst();
			else if (pick < 50)
				irq_setup_burst();
			else if (pick < 65)
				bank_burst();
			else if (pick < 85)
				wram_burst();
			else
				noise_burst();
		end
	endtask

	// every configuration in turn, one phase without any idling
	task automatic test_random_traffic();
		for (int i = 0; i < 8; i++) begin
			set_config(i[0], i[1], i[2]);
			no_gaps = (i == 3);
			run_traffic(PHASE_EVENTS);
		end
		no_gaps = 1'b0;
	endtask

	// receiver holds off while events keep coming, input must stall
	task automatic test_result_backpressure();
		wait_until_drained();
		hold_req = 1'b1;
		no_gaps = 1'b1;
		run_traffic(PRESSURE_EVENTS);
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.item = '0;
		res_ch.ready = 1'b0;
		reset_mapper_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_bank_switching();
		test_scanline_irq();
		test_work_ram();
		test_random_traffic();
		test_result_backpressure();

		wait_until_drained();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### bank_mapper_scanline_irq_unit.f
design/bmsi_pkg.sv
design/bmsi_ifs.sv
design/bmsi_ram.sv
design/bmsi_core.sv
design/bank_mapper_scanline_irq_unit.sv
tb/sv/tb_top.sv
